>>> rtl/core/slht_pkg.sv
// Shared types and constants for the smoothed level hysteresis tracker.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
package slht_pkg;

    localparam int Q16_W  = 17;
    localparam int STEP_W = 8;
    localparam int SAMP_W = 18;
    localparam int LVL_W  = 2;
    localparam int CFG_IDX_W = 3;

    typedef logic [Q16_W-1:0]  t_q16;
    typedef logic [STEP_W-1:0] t_steps;
    typedef logic [LVL_W-1:0]  t_level;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_q16 ONE_Q16 = 17'd65536;

    localparam t_level LVL_LOOSE  = 2'd0;
    localparam t_level LVL_LINKED = 2'd1;
    localparam t_level LVL_TIGHT  = 2'd2;

    localparam t_cfg_idx CFG_ALPHA           = 3'd0;
    localparam t_cfg_idx CFG_LOOSE_TO_LINKED = 3'd1;
    localparam t_cfg_idx CFG_LINKED_TO_LOOSE = 3'd2;
    localparam t_cfg_idx CFG_LINKED_TO_TIGHT = 3'd3;
    localparam t_cfg_idx CFG_TIGHT_TO_LINKED = 3'd4;

    localparam t_q16 ALPHA_RST           = 17'd6554;
    localparam t_q16 LOOSE_TO_LINKED_RST = 17'd36045;
    localparam t_q16 LINKED_TO_LOOSE_RST = 17'd22938;
    localparam t_q16 LINKED_TO_TIGHT_RST = 17'd52429;
    localparam t_q16 TIGHT_TO_LINKED_RST = 17'd42598;

    // Controller to datapath
    typedef struct packed {
        logic load;     // take the input item
        logic step;     // apply one smoothing step
        logic finish;   // classify and fill the output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic count_last;
    } t_status;

endpackage

>>> rtl/core/slht_ctrl.sv
// Sequencer for the tracker: accept, step loop, finish, output register valid.
// Depends on slht_pkg.
module slht_ctrl import slht_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = !i_status.count_zero;
                if (i_status.count_zero || i_status.count_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> rtl/core/slht_dp.sv
// Datapath: configuration registers, clamp, multiply-accumulate step, classifier,
// output register. Depends on slht_pkg.
module slht_dp import slht_pkg::*; #(
    parameter int MAX_STEPS = 255
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  t_cfg_idx                 i_cfg_index,
    input  t_q16                     i_cfg_data,
    input  logic signed [SAMP_W-1:0] i_sample,
    input  t_steps                   i_step_count,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    output t_level                   o_level,
    output logic                     o_changed,
    output t_q16                     o_clamped_sample,
    output t_q16                     o_smoothed_value
);

    localparam t_steps STEP_LIMIT =
        (MAX_STEPS >= ((1 << STEP_W) - 1)) ? t_steps'((1 << STEP_W) - 1) : t_steps'(MAX_STEPS);

    t_q16   r_alpha, r_l2k, r_k2l, r_k2t, r_t2k;
    t_q16   r_raw, r_avg, n_avg;
    logic   r_started, r_had_steps;
    t_level r_level, n_level;
    t_steps r_count;
    t_level r_out_level;
    logic   r_out_changed;
    t_q16   r_out_raw, r_out_avg;

    t_q16                     w_clamp;
    t_q16                     w_alpha_sat;
    logic signed [SAMP_W-1:0] w_diff;
    logic signed [SAMP_W-1:0] w_alpha_s;
    logic signed [2*SAMP_W-1:0] w_prod;
    logic signed [SAMP_W-1:0] w_inc;
    logic signed [SAMP_W-1:0] w_sum;

    // Clamp sample into 0..1.0
    always_comb begin
        if (i_sample[SAMP_W-1]) begin
            w_clamp = '0;
        end else if (i_sample[Q16_W-1] && (|i_sample[Q16_W-2:0])) begin
            w_clamp = ONE_Q16;
        end else begin
            w_clamp = i_sample[Q16_W-1:0];
        end
    end

    // One smoothing step: avg += floor(alpha * (raw - avg) / 2^16)
    assign w_alpha_sat = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;
    assign w_alpha_s   = $signed({1'b0, w_alpha_sat});
    assign w_diff      = $signed({1'b0, r_raw}) - $signed({1'b0, r_avg});
    assign w_prod      = w_alpha_s * w_diff;
    assign w_inc       = w_prod[SAMP_W+15:16];
    assign w_sum       = $signed({1'b0, r_avg}) + w_inc;
    assign n_avg       = w_sum[Q16_W-1:0];

    always_comb begin
        case (r_level)
            LVL_LOOSE:  n_level = (r_avg >= r_l2k) ? LVL_LINKED : LVL_LOOSE;
            LVL_LINKED: begin
                if (r_avg <= r_k2l) begin
                    n_level = LVL_LOOSE;
                end else if (r_avg >= r_k2t) begin
                    n_level = LVL_TIGHT;
                end else begin
                    n_level = LVL_LINKED;
                end
            end
            LVL_TIGHT:  n_level = (r_avg <= r_t2k) ? LVL_LINKED : LVL_TIGHT;
            default:    n_level = LVL_LOOSE;
        endcase
    end

    assign o_status.count_zero = (r_count == '0);
    assign o_status.count_last = (r_count == t_steps'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha   <= ALPHA_RST;
            r_l2k     <= LOOSE_TO_LINKED_RST;
            r_k2l     <= LINKED_TO_LOOSE_RST;
            r_k2t     <= LINKED_TO_TIGHT_RST;
            r_t2k     <= TIGHT_TO_LINKED_RST;
            r_started <= 1'b0;
            r_avg     <= '0;
            r_level   <= LVL_LOOSE;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALPHA:           r_alpha <= i_cfg_data;
                    CFG_LOOSE_TO_LINKED: r_l2k   <= i_cfg_data;
                    CFG_LINKED_TO_LOOSE: r_k2l   <= i_cfg_data;
                    CFG_LINKED_TO_TIGHT: r_k2t   <= i_cfg_data;
                    CFG_TIGHT_TO_LINKED: r_t2k   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_count <= (i_step_count > STEP_LIMIT) ? STEP_LIMIT : i_step_count;
                if (!r_started) begin
                    r_avg     <= w_clamp;
                    r_started <= 1'b1;
                end
            end else if (i_cmd.step) begin
                r_avg   <= n_avg;
                r_count <= r_count - t_steps'(1);
            end
            if (i_cmd.finish && r_had_steps) begin
                r_level <= n_level;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_raw       <= w_clamp;
            r_had_steps <= (i_step_count != '0);
        end
        if (i_cmd.finish) begin
            r_out_level   <= r_had_steps ? n_level : r_level;
            r_out_changed <= r_had_steps && (n_level != r_level);
            r_out_raw     <= r_raw;
            r_out_avg     <= r_avg;
        end
    end

    assign o_level          = r_out_level;
    assign o_changed        = r_out_changed;
    assign o_clamped_sample = r_out_raw;
    assign o_smoothed_value = r_out_avg;

endmodule

>>> rtl/core/smoothed_level_hysteresis_tracker.sv
// Sequence: an accepted item runs n smoothing steps, n = steps after saturation (none when
//   the step count is zero); one smoothing step per cycle through one 18x18 MAC.
// Items: a new item is accepted only once the previous one has left the step loop over the shared MAC;
//   a finished result waits in the output register while the next item is accepted.
// Reset: synchronous, active low; clears configuration to defaults, the smoothed state,
//   the level (loose) and the sequencer. Configuration writes are always ready.
module smoothed_level_hysteresis_tracker import slht_pkg::*; #(
    parameter int MAX_STEPS = 255
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input item channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SAMP_W-1:0] i_sample,
    input  t_steps                   i_step_count,
    // result item channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_level                   o_level,
    output logic                     o_changed,
    output t_q16                     o_clamped_sample,
    output t_q16                     o_smoothed_value,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  t_cfg_idx                 i_cfg_index,
    input  t_q16                     i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    // Registers live in the datapath; a write lands on any cycle.
    assign o_cfg_ready = 1'b1;

    // Sequencer: idle -> step loop -> finish, plus the output valid flag.
    slht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Clamp, smoothing MAC, hysteresis classifier and result register.
    slht_dp #(
        .MAX_STEPS (MAX_STEPS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid & o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_sample         (i_sample),
        .i_step_count     (i_step_count),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_level          (o_level),
        .o_changed        (o_changed),
        .o_clamped_sample (o_clamped_sample),
        .o_smoothed_value (o_smoothed_value)
    );

endmodule

>>> rtl/core/slht_checker.sv
// Port-level checker for the tracker, bound to the top level.
// Depends on slht_pkg.
module slht_checker import slht_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input t_level                   o_level,
    input logic                     o_changed,
    input t_q16                     o_clamped_sample,
    input t_q16                     o_smoothed_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_smoothed_value)
            && $stable(o_level) && $stable(o_changed) && $stable(o_clamped_sample))
        else $error("stalled result changed");

    // one item in flight: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous still in work");

    // delivered values stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_level <= LVL_TIGHT) && (o_smoothed_value <= ONE_Q16)
            && (o_clamped_sample <= ONE_Q16))
        else $error("result out of range");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state not cleared by reset");

endmodule

bind smoothed_level_hysteresis_tracker slht_checker u_slht_checker (.*);
